>>> hdl/tq_pkg.sv
// Shared types and constants for the triangular quantile unit.
`default_nettype none
package tq_pkg;
    localparam int PROB_W = 18;
    localparam int VAL_W  = 32;
    localparam int DIFF_W = 33;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    typedef struct packed {
        logic                    invalid;
        logic                    lower_branch;
        logic signed [VAL_W-1:0] base;
        logic [RAD_W-1:0]        radicand;
    } tq_job_t;
endpackage
`default_nettype wire

>>> hdl/tq_front.sv
// Front end: checks the bounds, forms the branch test and the radicand over a few stages.
`default_nettype none
module tq_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cdf_mode,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [tq_pkg::PROB_W-1:0] prob,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  lower_bound,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  upper_bound,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  peak,
    output logic                                  job_valid,
    output tq_pkg::tq_job_t                       job,
    input  wire logic                             job_stall
);
    import tq_pkg::*;

    localparam int QF_W = ((FRAC_BITS + 2 > PROB_W) ? FRAC_BITS + 2 : PROB_W) + 1;
    localparam int Q_W = FRAC_BITS + 2;
    localparam int P1_W = Q_W + DIFF_W;
    localparam int P2_W = P1_W + DIFF_W;
    localparam int ML = P1_W / 2;
    localparam int MH = P1_W - ML;
    localparam int PL_W = ML + DIFF_W;
    localparam int PH_W = MH + DIFF_W;

    // Stage 1: differences, q, validity.
    logic                     s1_valid_reg;
    logic                     s1_bad_reg;
    logic [Q_W-1:0]           s1_q_reg;
    logic [DIFF_W-1:0]        s1_len_reg, s1_a_reg, s1_b_reg;
    logic signed [VAL_W-1:0]  s1_lo_reg, s1_hi_reg;
    // Stage 2: q*len, (1-q)*len.
    logic                     s2_valid_reg;
    logic                     s2_bad_reg;
    logic [P1_W-1:0]          s2_ql_reg, s2_rl_reg;
    logic [DIFF_W-1:0]        s2_a_reg, s2_b_reg;
    logic signed [VAL_W-1:0]  s2_lo_reg, s2_hi_reg;
    // Stage 3: branch choice and the two partial products of the radicand.
    logic                     s3_valid_reg;
    logic                     s3_bad_reg;
    logic                     s3_low_reg;
    logic signed [VAL_W-1:0]  s3_base_reg;
    logic [PL_W-1:0]          s3_pl_reg;
    logic [PH_W-1:0]          s3_ph_reg;
    // Stage 4: radicand.
    logic                     s4_valid_reg;
    tq_job_t                  s4_job_reg;

    logic                     adv;
    logic signed [QF_W-1:0]   q_full;
    logic signed [DIFF_W-1:0] len_s, a_s, b_s;
    logic                     bad;
    logic                     lower_br;
    logic [P1_W-1:0]          mul_m;
    logic [DIFF_W-1:0]        mul_n;
    logic [P2_W-1:0]          prod;
    logic [RAD_W-1:0]         rad;

    assign adv = !(s4_valid_reg && job_stall);
    assign in_stall = !adv;
    assign job_valid = s4_valid_reg;
    assign job = s4_job_reg;

    always_comb
    begin
        q_full = cdf_mode ? QF_W'(prob)
                 : QF_W'(1 << FRAC_BITS) - QF_W'(prob);
        len_s = DIFF_W'(upper_bound) - DIFF_W'(lower_bound);
        a_s = DIFF_W'(peak) - DIFF_W'(lower_bound);
        b_s = DIFF_W'(upper_bound) - DIFF_W'(peak);
        bad = (lower_bound >= upper_bound) || (peak > upper_bound) || (lower_bound > peak)
              || (q_full < 0) || (q_full > QF_W'(1 << FRAC_BITS));
        lower_br = {2'b00, s2_ql_reg} < ({(P1_W - DIFF_W + 2)'(0), s2_a_reg} << FRAC_BITS);
        mul_m = lower_br ? s2_ql_reg : s2_rl_reg;
        mul_n = lower_br ? s2_a_reg : s2_b_reg;
        prod = (P2_W'(s3_ph_reg) << ML) + P2_W'(s3_pl_reg);
        rad = RAD_W'(prod >> FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bad_reg <= bad;
            s1_q_reg   <= Q_W'(q_full);
            s1_len_reg <= DIFF_W'(len_s);
            s1_a_reg   <= DIFF_W'(a_s);
            s1_b_reg   <= DIFF_W'(b_s);
            s1_lo_reg  <= lower_bound;
            s1_hi_reg  <= upper_bound;

            s2_bad_reg <= s1_bad_reg;
            s2_ql_reg  <= P1_W'(s1_q_reg) * P1_W'(s1_len_reg);
            s2_rl_reg  <= P1_W'(Q_W'(1 << FRAC_BITS) - s1_q_reg) * P1_W'(s1_len_reg);
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_lo_reg  <= s1_lo_reg;
            s2_hi_reg  <= s1_hi_reg;

            s3_bad_reg  <= s2_bad_reg;
            s3_low_reg  <= lower_br;
            s3_base_reg <= lower_br ? s2_lo_reg : s2_hi_reg;
            s3_pl_reg   <= PL_W'(mul_m[ML-1:0]) * PL_W'(mul_n);
            s3_ph_reg   <= PH_W'(mul_m[P1_W-1:ML]) * PH_W'(mul_n);

            s4_job_reg.invalid      <= s3_bad_reg;
            s4_job_reg.lower_branch <= s3_low_reg;
            s4_job_reg.base         <= s3_base_reg;
            s4_job_reg.radicand     <= s3_bad_reg ? '0 : rad;
        end
    end
endmodule
`default_nettype wire

>>> hdl/tq_queue.sv
// Short request queue between the front end and the square root pipeline.
`default_nettype none
module tq_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    output logic                 wr_stall,
    input  wire tq_pkg::tq_job_t wr_data,
    output logic                 rd_valid,
    output tq_pkg::tq_job_t      rd_data,
    input  wire logic            rd_stall
);
    import tq_pkg::*;

    tq_job_t    mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push, pop;

    assign wr_stall = (count_reg == 3'd4);
    assign rd_valid = (count_reg != 3'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push = wr_valid && !wr_stall;
    assign pop = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end
endmodule
`default_nettype wire

>>> hdl/tq_sqrt.sv
// Back end: pipelined integer square root, two result bits per stage, and the final add or subtract.
`default_nettype none
module tq_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            job_valid,
    output logic                                 job_stall,
    input  wire tq_pkg::tq_job_t                 job,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [tq_pkg::VAL_W-1:0]      quantile,
    output logic                                 invalid
);
    import tq_pkg::*;

    localparam int STAGES = ROOT_W / 2;

    logic                    v_reg    [STAGES+1];
    logic [RAD_W-1:0]        rem_reg  [STAGES+1];
    logic [ROOT_W-1:0]       root_reg [STAGES+1];
    logic [RAD_W-1:0]        sq_reg   [STAGES+1];
    logic                    bad_reg  [STAGES+1];
    logic                    low_reg  [STAGES+1];
    logic signed [VAL_W-1:0] base_reg [STAGES+1];
    logic                    adv;
    logic [RAD_W-1:0]        rem_next  [STAGES];
    logic [ROOT_W-1:0]       root_next [STAGES];
    logic [RAD_W-1:0]        sq_next   [STAGES];

    assign adv = !(v_reg[STAGES] && out_stall);
    assign job_stall = !adv;
    assign out_valid = v_reg[STAGES];
    assign invalid = bad_reg[STAGES];
    assign quantile = bad_reg[STAGES] ? '0
                      : (low_reg[STAGES] ? base_reg[STAGES] + signed'(root_reg[STAGES])
                                         : base_reg[STAGES] - signed'(root_reg[STAGES]));

    // Each stage settles two root bits. The square of the root so far is carried along,
    // so a trial square is that square plus the root shifted and one power of four.
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            logic [RAD_W-1:0]  trial;
            logic [RAD_W-1:0]  sq1;
            logic [ROOT_W-1:0] rt1;
            trial = sq_reg[i] + (RAD_W'(root_reg[i]) << (ROOT_W - 2*i))
                    + (RAD_W'(1) << (2*ROOT_W - 2 - 4*i));
            if (trial <= rem_reg[i])
            begin
                rt1 = root_reg[i] | (ROOT_W'(1) << (ROOT_W - 1 - 2*i));
                sq1 = trial;
            end
            else
            begin
                rt1 = root_reg[i];
                sq1 = sq_reg[i];
            end
            trial = sq1 + (RAD_W'(rt1) << (ROOT_W - 1 - 2*i))
                    + (RAD_W'(1) << (2*ROOT_W - 4 - 4*i));
            rem_next[i] = rem_reg[i];
            if (trial <= rem_reg[i])
            begin
                root_next[i] = rt1 | (ROOT_W'(1) << (ROOT_W - 2 - 2*i));
                sq_next[i]   = trial;
            end
            else
            begin
                root_next[i] = rt1;
                sq_next[i]   = sq1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= job_valid;
            for (int i = 0; i < STAGES; i++)
                v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= job.radicand;
            root_reg[0] <= '0;
            sq_reg[0]   <= '0;
            bad_reg[0]  <= job.invalid;
            low_reg[0]  <= job.lower_branch;
            base_reg[0] <= job.base;
            for (int i = 0; i < STAGES; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                root_reg[i+1] <= root_next[i];
                sq_reg[i+1]   <= sq_next[i];
                bad_reg[i+1]  <= bad_reg[i];
                low_reg[i+1]  <= low_reg[i];
                base_reg[i+1] <= base_reg[i];
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/triangular_quantile_unit.sv
// Top level of the triangular distribution quantile unit.
// The input channel (in_valid/in_stall) takes one request per cycle while in_stall is
// low: a probability and the minimum, maximum and peak of a triangular distribution. The
// output channel (out_valid/out_stall) returns the quantile and an invalid flag, one result
// per request, in request order. A request passes through the four front-end stages that
// check the bounds and form the radicand, then the four-entry queue, and then the square
// root stages that settle two root bits each. The multipliers and root stages are fully
// pipelined, so one request per cycle moves through them unless the receiver stalls.
// When the receiver stalls, the root pipeline holds, the queue fills, and then the front
// end stalls the sender.
// Reset empties all stages and the queue and sets the tail mode to one (lower tail).
// cfg_we writes cfg_wdata into the tail mode; write it only while idle.
`default_nettype none
module triangular_quantile_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [tq_pkg::PROB_W-1:0] prob,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  lower_bound,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  upper_bound,
    input  wire logic signed [tq_pkg::VAL_W-1:0]  peak,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [tq_pkg::VAL_W-1:0]       quantile,
    output logic                                  invalid
);
    import tq_pkg::*;

    logic    mode_reg;
    logic    fq_valid, fq_stall, qs_valid, qs_stall;
    tq_job_t fq_job, qs_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    tq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .cdf_mode(mode_reg),
        .in_valid(in_valid), .in_stall(in_stall), .prob(prob),
        .lower_bound(lower_bound), .upper_bound(upper_bound), .peak(peak),
        .job_valid(fq_valid), .job(fq_job), .job_stall(fq_stall)
    );

    tq_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_job),
        .rd_valid(qs_valid), .rd_data(qs_job), .rd_stall(qs_stall)
    );

    tq_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qs_valid), .job_stall(qs_stall), .job(qs_job),
        .out_valid(out_valid), .out_stall(out_stall),
        .quantile(quantile), .invalid(invalid)
    );
endmodule
`default_nettype wire
